[hw/rtl/qlc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qlc_pkg
// Shared widths, register codes and types of the quintic lateral
// coefficient pipeline.
// ----------------------------------------------------------------------------
package qlc_pkg;

  localparam int COEF_FRAC_BITS = 40;

  // register map codes (index = paddr[3:2])
  localparam logic [1:0] REG_START_OFFSET    = 2'd0;
  localparam logic [1:0] REG_START_SLOPE     = 2'd1;
  localparam logic [1:0] REG_START_CURVATURE = 2'd2;
  localparam logic [1:0] REG_START_STATION   = 2'd3;

  // constant-scaled end-condition terms
  localparam int K0W = 40;
  localparam int K1W = 38;
  localparam int K2W = 36;
  // signed numerator, magnitude, shifted magnitude, denominator
  localparam int NW  = 100;
  localparam int MW  = NW + COEF_FRAC_BITS + 31;
  localparam int DW  = 155;
  // quotient bits produced by the divider
  localparam int QW  = 65;

  localparam int SH3 = COEF_FRAC_BITS - 1;
  localparam int SH4 = COEF_FRAC_BITS + 15;
  localparam int SH5 = COEF_FRAC_BITS + 31;

  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = QW + 1;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

  typedef struct packed {
    logic signed [31:0] start_offset;
    logic signed [31:0] start_slope;
    logic signed [31:0] start_curvature;
    logic signed [31:0] start_station;
  } cfg_t;

  typedef struct packed {
    logic          neg;
    logic [NW-1:0] mag;
    logic [DW-1:0] den;
  } num_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [30:0] length;
    logic [31:0] smax;
    logic        zero;
  } side_t;

  // round(v * 2^COEF_FRAC_BITS / 2^db), ties away from zero
  function automatic logic [63:0] scale_cfg(logic signed [31:0] v, int db);
    logic [32:0] m;
    logic [33+COEF_FRAC_BITS:0] e;
    logic [63:0] r;
    m = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    e = ({{(COEF_FRAC_BITS + 1){1'b0}}, m} << COEF_FRAC_BITS)
        + ({{(33 + COEF_FRAC_BITS){1'b0}}, 1'b1} << (db - 1));
    e = e >> db;
    r = e[63:0];
    return v[31] ? (64'd0 - r) : r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/qlc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qlc_front
// Six-stage product pipeline: forms the signed numerators and the powers
// T^3, T^4, T^5 of the three higher coefficients.
// ----------------------------------------------------------------------------
module qlc_front (
  input  wire  logic                   clk_i,
  input  wire  logic                   en_i,
  input  wire  qlc_pkg::cfg_t          cfg_i,
  input  wire  logic [31:0]            end_offset_i,
  input  wire  logic [31:0]            end_slope_i,
  input  wire  logic [31:0]            end_curvature_i,
  input  wire  logic [30:0]            path_length_i,
  output       qlc_pkg::num_t [2:0]    num_o
);

  localparam int K0W = qlc_pkg::K0W;
  localparam int K1W = qlc_pkg::K1W;
  localparam int K2W = qlc_pkg::K2W;
  localparam int NW  = qlc_pkg::NW;
  localparam int DW  = qlc_pkg::DW;

  // stage 1
  logic signed [32:0] h1_q;
  logic signed [31:0] d1_q, a1_q;
  logic [30:0]        t1_q;
  // stage 2
  logic signed [K0W-1:0] k0_2_q [3];
  logic signed [K1W-1:0] k1_2_q [3];
  logic signed [K2W-1:0] k2_2_q [3];
  logic [61:0]           t2_2_q;
  logic [30:0]           t2_q;
  // stage 3
  logic signed [K0W-1:0]    k0_3_q [3];
  logic signed [K1W+31:0]   k1t_3_q [3];
  logic signed [K2W+31:0]   k2t_3_q [3];
  logic [61:0]              pa_q, pb_q, ll_q, lh_q, hh_q;
  logic [30:0]              t3_q;
  // stage 4
  logic signed [K0W-1:0]    k0_4_q [3];
  logic signed [K1W+31:0]   k1t_4_q [3];
  logic [64:0]              plo_4_q [3];
  logic signed [65:0]       phi_4_q [3];
  logic [92:0]              tp3_4_q;
  logic [123:0]             tp4_4_q;
  logic [30:0]              t4_q;
  // stage 5
  logic signed [NW-1:0]     n_5_q [3];
  logic [61:0]              p5_5_q [4];
  logic [92:0]              tp3_5_q;
  logic [123:0]             tp4_5_q;
  // stage 6
  qlc_pkg::num_t [2:0]      num_q;

  logic signed [31:0] ts2, ts3, ts4;
  logic signed [K0W-1:0] hx;
  logic signed [K1W-1:0] d0x, d1x, dsx;
  logic signed [K2W-1:0] a0x, a1x;
  logic [154:0] t5_sum;

  assign ts2 = $signed({1'b0, t2_q});
  assign ts3 = $signed({1'b0, t3_q});
  assign ts4 = $signed({1'b0, t4_q});
  assign hx  = K0W'(h1_q);
  assign d0x = K1W'(cfg_i.start_slope);
  assign d1x = K1W'(d1_q);
  assign dsx = d0x + d1x;
  assign a0x = K2W'(cfg_i.start_curvature);
  assign a1x = K2W'(a1_q);

  always_comb begin
    t5_sum = '0;
    for (int i = 0; i < 4; i++) begin
      t5_sum = t5_sum + (155'(p5_5_q[i]) << (31 * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: offset difference
      h1_q <= $signed({end_offset_i[31], end_offset_i})
            - $signed({cfg_i.start_offset[31], cfg_i.start_offset});
      d1_q <= $signed(end_slope_i);
      a1_q <= $signed(end_curvature_i);
      t1_q <= path_length_i;

      // stage 2: constant multiples, T^2
      k0_2_q[0] <= (hx <<< 4) + (hx <<< 2);
      k0_2_q[1] <= (hx <<< 1) - (hx <<< 5);
      k0_2_q[2] <= (hx <<< 3) + (hx <<< 2);
      k1_2_q[0] <= -((d1x <<< 3) + (d0x <<< 3) + (d0x <<< 2));
      k1_2_q[1] <= (d1x <<< 4) - (d1x <<< 1) + (d0x <<< 4);
      k1_2_q[2] <= -((dsx <<< 2) + (dsx <<< 1));
      k2_2_q[0] <= a1x - (a0x <<< 1) - a0x;
      k2_2_q[1] <= (a0x <<< 1) + a0x - (a1x <<< 1);
      k2_2_q[2] <= a1x - a0x;
      t2_2_q    <= 62'(t1_q) * 62'(t1_q);
      t2_q      <= t1_q;

      // stage 3: first products by T
      for (int c = 0; c < 3; c++) begin
        k0_3_q[c]  <= k0_2_q[c];
        k1t_3_q[c] <= k1_2_q[c] * ts2;
        k2t_3_q[c] <= k2_2_q[c] * ts2;
      end
      pa_q <= 62'(t2_2_q[30:0]) * 62'(t2_q);
      pb_q <= 62'(t2_2_q[61:31]) * 62'(t2_q);
      ll_q <= 62'(t2_2_q[30:0]) * 62'(t2_2_q[30:0]);
      lh_q <= 62'(t2_2_q[30:0]) * 62'(t2_2_q[61:31]);
      hh_q <= 62'(t2_2_q[61:31]) * 62'(t2_2_q[61:31]);
      t3_q <= t2_q;

      // stage 4: T^3, T^4; k2*T*T split in halves
      for (int c = 0; c < 3; c++) begin
        k0_4_q[c]  <= k0_3_q[c];
        k1t_4_q[c] <= k1t_3_q[c];
        plo_4_q[c] <= 65'(k2t_3_q[c][33:0]) * 65'(t3_q);
        phi_4_q[c] <= $signed(k2t_3_q[c][67:34]) * ts3;
      end
      tp3_4_q <= 93'(pa_q) + (93'(pb_q) << 31);
      // cross term counted twice: 2 * 2^31
      tp4_4_q <= 124'(ll_q) + (124'(lh_q) << 32) + (124'(hh_q) << 62);
      t4_q    <= t3_q;

      // stage 5: numerators; partial products of T^5
      for (int c = 0; c < 3; c++) begin
        n_5_q[c] <= (NW'(k0_4_q[c]) <<< 32) + (NW'(k1t_4_q[c]) <<< 16)
                  + (NW'(phi_4_q[c]) <<< 34) + NW'($signed({1'b0, plo_4_q[c]}));
      end
      for (int i = 0; i < 4; i++) begin
        p5_5_q[i] <= 62'(tp4_4_q[31*i +: 31]) * 62'(ts4[30:0]);
      end
      tp3_5_q <= tp3_4_q;
      tp4_5_q <= tp4_4_q;

      // stage 6: sign and magnitude, T^5
      for (int c = 0; c < 3; c++) begin
        num_q[c].neg <= n_5_q[c][NW-1];
        num_q[c].mag <= n_5_q[c][NW-1] ? (NW'(0) - n_5_q[c]) : n_5_q[c];
      end
      num_q[0].den <= DW'(tp3_5_q);
      num_q[1].den <= DW'(tp4_5_q);
      num_q[2].den <= t5_sum;
    end
  end

  assign num_o = num_q;

endmodule
`default_nettype wire

[hw/rtl/qlc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qlc_div
// Pipelined restoring divider, one quotient bit per stage, with round to
// nearest (ties away) and saturation to a signed 64-bit result.
// ----------------------------------------------------------------------------
module qlc_div (
  input  wire  logic                      clk_i,
  input  wire  logic                      en_i,
  input  wire  logic                      neg_i,
  input  wire  logic [qlc_pkg::MW-1:0]    mag_i,
  input  wire  logic [qlc_pkg::DW-1:0]    den_i,
  output       logic [63:0]               coef_o
);

  localparam int MW = qlc_pkg::MW;
  localparam int DW = qlc_pkg::DW;
  localparam int QW = qlc_pkg::QW;

  logic          neg_q  [QW+1];
  logic          over_q [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] low_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];

  logic [DW-1:0] head;
  logic [DW:0]   trial [QW];
  logic          take  [QW];
  logic          rnd;
  logic [QW:0]   sum, limit, sat;

  // quotient of 2^QW or more saturates anyway
  assign head = DW'(mag_i[MW-1:QW]);

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      trial[j] = {rem_q[j], low_q[j][QW-1]};
      take[j]  = trial[j] >= {1'b0, den_q[j]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= neg_i;
      over_q[0] <= head >= den_i;
      den_q[0]  <= den_i;
      rem_q[0]  <= head;
      low_q[0]  <= mag_i[QW-1:0];
      quo_q[0]  <= '0;
      for (int j = 0; j < QW; j++) begin
        neg_q[j+1]  <= neg_q[j];
        over_q[j+1] <= over_q[j];
        den_q[j+1]  <= den_q[j];
        rem_q[j+1]  <= take[j] ? DW'(trial[j] - {1'b0, den_q[j]}) : trial[j][DW-1:0];
        low_q[j+1]  <= {low_q[j][QW-2:0], 1'b0};
        quo_q[j+1]  <= {quo_q[j][QW-2:0], take[j]};
      end
    end
  end

  always_comb begin
    rnd   = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};
    sum   = {1'b0, quo_q[QW]} + (QW+1)'(rnd);
    limit = neg_q[QW] ? ((QW+1)'(1) << 63) : (((QW+1)'(1) << 63) - (QW+1)'(1));
    sat   = (over_q[QW] || (sum > limit)) ? limit : sum;
    coef_o = neg_q[QW] ? (64'd0 - sat[63:0]) : sat[63:0];
  end

endmodule
`default_nettype wire

[hw/rtl/quintic_lateral_coefficients_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quintic_lateral_coefficients_top
// Quintic lateral path coefficients from a configured start state and a
// streamed end condition.
// ----------------------------------------------------------------------------
// Usage:
//  - Start offset, slope, curvature and station are written over the APB
//    port (byte addresses 0x0, 0x4, 0x8, 0xC) while no beat is in flight.
//  - Slave stream beat: end offset, slope, curvature and path length.
//  - Master stream beat: six Q24.40 coefficients plus station range, length
//    and end offset; tuser carries the zero-length flag.
//  - One beat per cycle sustained while the master side does not stall. From
//    acceptance to result valid: 6 product stages, one divider setup stage,
//    65 restoring division stages (one quotient bit each) and the output register.
//  - A stall on the master side freezes the whole pipeline; s_axis_tready_o
//    drops only while a result waits and m_axis_tready_i is low.
//  - Reset clears the registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module quintic_lateral_coefficients_top (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         psel,
  input  wire  logic         penable,
  input  wire  logic         pwrite,
  input  wire  logic [3:0]   paddr,
  input  wire  logic [31:0]  pwdata,
  output       logic [31:0]  prdata,
  output       logic         pready,
  input  wire  logic         s_axis_tvalid_i,
  output       logic         s_axis_tready_o,
  // [31:0] end_offset, [63:32] end_slope, [95:64] end_curvature,
  // [126:96] path_length, [127] zero
  input  wire  logic [127:0] s_axis_tdata_i,
  output       logic         m_axis_tvalid_o,
  input  wire  logic         m_axis_tready_i,
  // [63:0] coef0 .. [383:320] coef5, [415:384] station_min,
  // [447:416] station_max, [478:448] length_out, [510:479] offset_out, [511] zero
  output       logic [511:0] m_axis_tdata_o,
  // [0] length_error
  output       logic [0:0]   m_axis_tuser_o
);

  localparam int LAT = qlc_pkg::PIPE_LAT;
  localparam int MW  = qlc_pkg::MW;

  qlc_pkg::cfg_t        cfg_q;
  qlc_pkg::num_t [2:0]  num;
  qlc_pkg::side_t       side_d;
  qlc_pkg::side_t       sb_q  [LAT];
  logic                 vld_q [LAT];
  logic                 out_vld_q;
  logic [511:0]         out_data_q;
  logic                 out_err_q;
  logic                 en, accept, wr;
  logic [63:0]          coef_hi [3];
  logic [MW-1:0]        mag_sh  [3];
  logic [32:0]          smax_sum;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        qlc_pkg::REG_START_OFFSET:    cfg_q.start_offset    <= pwdata;
        qlc_pkg::REG_START_SLOPE:     cfg_q.start_slope     <= pwdata;
        qlc_pkg::REG_START_CURVATURE: cfg_q.start_curvature <= pwdata;
        qlc_pkg::REG_START_STATION:   cfg_q.start_station   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      qlc_pkg::REG_START_OFFSET:    prdata = cfg_q.start_offset;
      qlc_pkg::REG_START_SLOPE:     prdata = cfg_q.start_slope;
      qlc_pkg::REG_START_CURVATURE: prdata = cfg_q.start_curvature;
      qlc_pkg::REG_START_STATION:   prdata = cfg_q.start_station;
      default:                      prdata = '0;
    endcase
  end

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  // end station saturates only upward, length is never negative
  assign smax_sum = {cfg_q.start_station[31], cfg_q.start_station}
                  + {2'b00, s_axis_tdata_i[126:96]};

  always_comb begin
    side_d.offset = s_axis_tdata_i[31:0];
    side_d.length = s_axis_tdata_i[126:96];
    side_d.smax   = (smax_sum[32] != smax_sum[31]) ? 32'h7FFF_FFFF : smax_sum[31:0];
    side_d.zero   = s_axis_tdata_i[126:96] == 31'd0;
  end

  qlc_front u_front (
    .clk_i           (clk_i),
    .en_i            (en),
    .cfg_i           (cfg_q),
    .end_offset_i    (s_axis_tdata_i[31:0]),
    .end_slope_i     (s_axis_tdata_i[63:32]),
    .end_curvature_i (s_axis_tdata_i[95:64]),
    .path_length_i   (s_axis_tdata_i[126:96]),
    .num_o           (num)
  );

  assign mag_sh[0] = MW'(num[0].mag) << qlc_pkg::SH3;
  assign mag_sh[1] = MW'(num[1].mag) << qlc_pkg::SH4;
  assign mag_sh[2] = MW'(num[2].mag) << qlc_pkg::SH5;

  for (genvar c = 0; c < 3; c++) begin : g_div
    qlc_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .neg_i  (num[c].neg),
      .mag_i  (mag_sh[c]),
      .den_i  (num[c].den),
      .coef_o (coef_hi[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= accept;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= side_d;
      for (int i = 1; i < LAT; i++) sb_q[i] <= sb_q[i-1];
      if (sb_q[LAT-1].zero) begin
        out_data_q[383:0] <= '0;
      end else begin
        out_data_q[63:0]    <= qlc_pkg::scale_cfg(cfg_q.start_offset, 16);
        out_data_q[127:64]  <= qlc_pkg::scale_cfg(cfg_q.start_slope, 16);
        out_data_q[191:128] <= qlc_pkg::scale_cfg(cfg_q.start_curvature, 17);
        out_data_q[255:192] <= coef_hi[0];
        out_data_q[319:256] <= coef_hi[1];
        out_data_q[383:320] <= coef_hi[2];
      end
      out_data_q[415:384] <= cfg_q.start_station;
      out_data_q[447:416] <= sb_q[LAT-1].smax;
      out_data_q[478:448] <= sb_q[LAT-1].length;
      out_data_q[510:479] <= sb_q[LAT-1].offset;
      out_data_q[511]     <= 1'b0;
      out_err_q           <= sb_q[LAT-1].zero;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_err_q;

  a_err_zero_coef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[383:0] == '0)
    else $error("zero-length result with nonzero coefficients");

  a_err_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[478:448] == 31'd0) == m_axis_tuser_o[0])
    else $error("length flag disagrees with length field");

  a_station_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      $signed(m_axis_tdata_o[447:416]) >= $signed(m_axis_tdata_o[415:384]))
    else $error("end station below start station");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the quintic lateral coefficient block. End conditions
// go in through a queue-fed driver and the start state through the APB port,
// over several register settings. A local wide-integer predictor works out
// each expected beat, and a monitor compares the results field by field, in
// order. Both sides idle in random bursts, and the output side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [31:0] end_offset;
    logic [31:0] end_slope;
    logic [31:0] end_curvature;
    logic [30:0] path_length;
  } cond_t;

  typedef struct {
    logic [63:0] coef [6];
    logic [31:0] station_min;
    logic [31:0] station_max;
    logic [30:0] length_out;
    logic [31:0] offset_out;
    logic        length_error;
  } coefs_t;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG    = 3000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [511:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  qlc_pkg::cfg_t start_cfg = '0;
  cond_t  cond_queue [$];
  coefs_t coefs_queue [$];
  cond_t  cur_cond;
  int     errors = 0;
  int     src_gap = 0, snk_gap = 0, hold_left = 0, idle_cycles = 0;
  bit     calm = 1'b0, hold_req = 1'b0, hold_done = 1'b0;

  always #2 clk_i = ~clk_i;

  quintic_lateral_coefficients_top dut (.*);

  // round(num * 2^sh / den), ties away from zero, saturated to 64 bits
  function automatic logic [63:0] round_q(wide_t num, int sh, logic [255:0] den);
    logic [255:0] mag, quo, rem, lim;
    bit neg;
    neg = num[255];
    mag = neg ? $unsigned(-num) : $unsigned(num);
    mag = mag << sh;
    quo = mag / den;
    rem = mag % den;
    if ((rem << 1) >= den) quo = quo + 1;
    lim = neg ? (256'd1 << 63) : ((256'd1 << 63) - 1);
    if (quo > lim) quo = lim;
    return neg ? (64'd0 - quo[63:0]) : quo[63:0];
  endfunction

  // k0*2^32 + k1*T*2^16 + k2*T^2, units of 2^-48
  function automatic wide_t poly_num(longint k0, longint k1, longint k2, wide_t tw);
    wide_t a, b, c;
    a = k0;
    b = k1;
    c = k2;
    return (a <<< 32) + ((b * tw) <<< 16) + c * tw * tw;
  endfunction

  function automatic coefs_t calc_coefs(cond_t c, qlc_pkg::cfg_t cf);
    coefs_t r;
    longint x0, d0, a0, s0, x1, d1, a1, h, smax;
    wide_t tw;
    logic [255:0] t3;
    x0 = longint'(cf.start_offset);
    d0 = longint'(cf.start_slope);
    a0 = longint'(cf.start_curvature);
    s0 = longint'(cf.start_station);
    x1 = longint'(signed'(c.end_offset));
    d1 = longint'(signed'(c.end_slope));
    a1 = longint'(signed'(c.end_curvature));
    tw = wide_t'(c.path_length);
    t3 = tw * tw * tw;
    h = x1 - x0;
    if (c.path_length == 0) begin
      for (int i = 0; i < 6; i++) r.coef[i] = '0;
      r.length_error = 1'b1;
    end else begin
      r.coef[0] = round_q(x0, qlc_pkg::COEF_FRAC_BITS, 65536);
      r.coef[1] = round_q(d0, qlc_pkg::COEF_FRAC_BITS, 65536);
      r.coef[2] = round_q(a0, qlc_pkg::COEF_FRAC_BITS, 131072);
      r.coef[3] = round_q(poly_num(20 * h, -(8 * d1 + 12 * d0), a1 - 3 * a0, tw),
                          qlc_pkg::COEF_FRAC_BITS - 1, t3);
      r.coef[4] = round_q(poly_num(-30 * h, 14 * d1 + 16 * d0, 3 * a0 - 2 * a1, tw),
                          qlc_pkg::COEF_FRAC_BITS + 15, t3 * tw);
      r.coef[5] = round_q(poly_num(12 * h, -6 * (d0 + d1), a1 - a0, tw),
                          qlc_pkg::COEF_FRAC_BITS + 31, t3 * tw * tw);
      r.length_error = 1'b0;
    end
    smax = s0 + longint'(c.path_length);
    if (smax > 64'sd2147483647) smax = 64'sd2147483647;
    r.station_min = cf.start_station;
    r.station_max = smax[31:0];
    r.length_out  = c.path_length;
    r.offset_out  = c.end_offset;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      logic nv;
      nv = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        coefs_queue.push_back(calc_coefs(cur_cond, start_cfg));
        void'(cond_queue.pop_front());
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
        end else if (cond_queue.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            src_gap <= $urandom_range(0, 7);
          end else begin
            nv = 1'b1;
            cur_cond = cond_queue[0];
            s_axis_tdata_i <= {1'b0, cur_cond.path_length, cur_cond.end_curvature,
                               cur_cond.end_slope, cur_cond.end_offset};
          end
        end
      end
      s_axis_tvalid_i <= nv;
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      logic nr;
      nr = 1'b1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        coefs_t got, want;
        for (int i = 0; i < 6; i++) got.coef[i] = m_axis_tdata_o[64*i +: 64];
        got.station_min  = m_axis_tdata_o[415:384];
        got.station_max  = m_axis_tdata_o[447:416];
        got.length_out   = m_axis_tdata_o[478:448];
        got.offset_out   = m_axis_tdata_o[510:479];
        got.length_error = m_axis_tuser_o[0];
        if (coefs_queue.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_axis_tdata_o);
          errors++;
        end else begin
          want = coefs_queue.pop_front();
          for (int i = 0; i < 6; i++)
            if (got.coef[i] !== want.coef[i]) begin
              $display("%0t: coef%0d exp %h got %h", $time, i, want.coef[i], got.coef[i]);
              errors++;
            end
          if (got.station_min !== want.station_min) begin
            $display("%0t: station_min exp %h got %h", $time, want.station_min,
                     got.station_min);
            errors++;
          end
          if (got.station_max !== want.station_max) begin
            $display("%0t: station_max exp %h got %h", $time, want.station_max,
                     got.station_max);
            errors++;
          end
          if (got.length_out !== want.length_out) begin
            $display("%0t: length_out exp %h got %h", $time, want.length_out,
                     got.length_out);
            errors++;
          end
          if (got.offset_out !== want.offset_out) begin
            $display("%0t: offset_out exp %h got %h", $time, want.offset_out,
                     got.offset_out);
            errors++;
          end
          if (got.length_error !== want.length_error) begin
            $display("%0t: length_error exp %b got %b", $time, want.length_error,
                     got.length_error);
            errors++;
          end
        end
      end
      if ((hold_req && !hold_done) || hold_left > 0) begin
        nr = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        nr = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        snk_gap <= $urandom_range(0, 7);
        nr = 1'b0;
      end
      m_axis_tready_i <= nr;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cond_queue.size() == 0 && coefs_queue.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qlc_pkg::REG_START_OFFSET:    start_cfg.start_offset    = val;
      qlc_pkg::REG_START_SLOPE:     start_cfg.start_slope     = val;
      qlc_pkg::REG_START_CURVATURE: start_cfg.start_curvature = val;
      qlc_pkg::REG_START_STATION:   start_cfg.start_station   = val;
      default: ;
    endcase
  endtask

  task automatic set_start(logic [31:0] x0, logic [31:0] d0, logic [31:0] a0,
                           logic [31:0] s0);
    reg_write(qlc_pkg::REG_START_OFFSET, x0);
    reg_write(qlc_pkg::REG_START_SLOPE, d0);
    reg_write(qlc_pkg::REG_START_CURVATURE, a0);
    reg_write(qlc_pkg::REG_START_STATION, s0);
  endtask

  task automatic add_cond(logic [31:0] x1, logic [31:0] d1, logic [31:0] a1,
                          logic [30:0] t);
    cond_t c;
    c.end_offset = x1;
    c.end_slope = d1;
    c.end_curvature = a1;
    c.path_length = t;
    cond_queue.push_back(c);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(1, 255));
      3, 4: return 31'($urandom);
      default: return 31'($urandom_range(32'h0000_4000, 32'h0100_0000));
    endcase
  endfunction

  task automatic drain();
    wait (cond_queue.size() == 0 && coefs_queue.size() == 0);
    repeat (qlc_pkg::PIPE_LAT + 4) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset start state, field extremes and the zero-length case
    add_cond(32'h0, 32'h0, 32'h0, 31'h0);
    add_cond(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h0);
    add_cond(32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000);
    add_cond(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h1);
    add_cond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h1);
    add_cond(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    add_cond(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    add_cond(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    add_cond(32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 31'h0002_0000);
    add_cond(32'h0050_0000, 32'h0, 32'h0, 31'h0032_0000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_start(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        1: set_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        2: set_start(32'h0, 32'h0, 32'h0, 32'h0);
        default: set_start(rand_q(), rand_q(), rand_q(), $urandom);
      endcase
      if (ph < 2) begin
        // station_max saturation and zero length under extreme start state
        add_cond(32'h0, 32'h0, 32'h0, 31'h7fff_ffff);
        add_cond(32'h0, 32'h0, 32'h0, 31'h0);
        add_cond(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h1);
      end
      calm = (ph == 5);
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < 72; i++)
        add_cond(rand_q(), rand_q(), rand_q(), rand_len());
      drain();
    end

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
